/* src/nullable_column_stream_parser_unit_macros.svh */
// Assertion macros used by the parser controller.
`ifndef NULLABLE_COLUMN_STREAM_PARSER_UNIT_MACROS_SVH
`define NULLABLE_COLUMN_STREAM_PARSER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCSP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define NCSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

/* src/ncsp_pkg.sv */
// ----------------------------------------------------------------------------
// ncsp_pkg
// Types and codes shared by the column parser controller and datapath.
// ----------------------------------------------------------------------------
package ncsp_pkg;

  localparam logic [2:0] RK_VALUE  = 3'd0;
  localparam logic [2:0] RK_TEXT   = 3'd1;
  localparam logic [2:0] RK_EMPTY  = 3'd2;
  localparam logic [2:0] RK_DONE   = 3'd3;
  localparam logic [2:0] RK_BADLEN = 3'd4;

  localparam logic [1:0] REG_POSITION_COUNT = 2'd0;
  localparam logic [1:0] REG_VALUE_KIND     = 2'd1;

  localparam logic [1:0] KIND_BOOL  = 2'd0;
  localparam logic [1:0] KIND_FIX4  = 2'd1;
  localparam logic [1:0] KIND_FIX8  = 2'd2;
  localparam logic [1:0] KIND_TEXT  = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR, PH_NMAP, PH_BMAP, PH_FIXED, PH_TLEN, PH_TBYTES
  } phase_t;

  typedef enum logic [3:0] {
    ST_WAIT, ST_HDRCHK, ST_BEGIN, ST_BCHK, ST_BEND, ST_FEMIT, ST_TCHK,
    ST_SKRD, ST_SKCHK, ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {VS_ACC, VS_BIT, VS_BYTE, VS_ZERO} vsel_t;
  typedef enum logic [1:0] {PS_POS, PS_BIT, PS_ZERO} psel_t;

  typedef struct packed {
    logic       hdr_latch;
    logic       clr_pos;
    logic       clr_work;
    logic       map_wr;
    logic       bool_ld;
    logic       bit_inc;
    logic       pos_inc;
    logic       pos_add8;
    logic       acc_shift;
    logic       len_load;
    logic       bc_dec;
    logic       emit;
    logic [2:0] emit_kind;
    vsel_t      vsel;
    psel_t      psel;
    logic       emit_end;
    logic       flush;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cnt_zero;
    logic       nmp;
    logic       map_end;
    logic       bc_full;
    logic       len_neg;
    logic       len_zero;
    logic       text_end;
    logic       pos_end;
    logic       is_null;
    logic       bit_ok;
    logic       bit_last;
    logic       pend_valid;
    logic       slot_free;
    logic       can_emit;
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  position;
    logic [63:0] value;
    logic        vend;
    logic        hnm;
  } result_t;

endpackage

/* src/ncsp_datapath.sv */
// ----------------------------------------------------------------------------
// ncsp_datapath
// Configuration registers, column counters, null bitmap memory and the
// pending and output result registers.
// ----------------------------------------------------------------------------
module ncsp_datapath import ncsp_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [7:0]  data_byte,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [2:0]  result_kind,
  output logic [9:0]  position,
  output logic [63:0] value,
  output logic        value_end,
  output logic        had_null_map,
  output logic        last
);

  localparam int CW   = $clog2(MAX_POSITIONS + 1);
  localparam int ROWS = (MAX_POSITIONS + 7) / 8;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [10:0]   position_count;
  logic [1:0]    value_kind;
  logic          nmp;
  logic [1:0]    col_kind;
  logic [CW-1:0] col_cnt;
  logic [CW-1:0] pos;
  logic [30:0]   bc;
  logic [63:0]   acc;
  logic [2:0]    bit_idx;
  logic [7:0]    bbyte;
  logic [7:0]    row_q;
  logic [7:0]    nmem [ROWS];
  result_t       pend;
  logic          pend_valid;
  result_t       res_new;
  logic          push;
  logic [CW-1:0] cnt_clamp;
  logic [CW:0]   pos_bit;
  logic [CW:0]   pos_p8;
  logic [RAW-1:0] row_addr;
  logic [63:0]   acc_next;
  logic [4:0]    need;

  assign cnt_clamp = (32'(position_count) > 32'(MAX_POSITIONS)) ?
                     CW'(MAX_POSITIONS) : CW'(position_count);
  assign pos_bit  = {1'b0, pos} + (CW+1)'(bit_idx);
  assign pos_p8   = {1'b0, pos} + (CW+1)'(8);
  assign row_addr = RAW'(pos >> 3);
  assign need     = (col_kind == KIND_FIX8) ? 5'd8 : 5'd4;

  always_comb begin
    acc_next = {acc[55:0], data_byte};
    if (col_kind == KIND_TEXT) begin
      acc_next[63:32] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      value_kind     <= KIND_FIX4;
    end else if (cfg_valid) begin
      if (cfg_index == REG_POSITION_COUNT) begin
        position_count <= cfg_data;
      end else if (cfg_index == REG_VALUE_KIND) begin
        value_kind <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nmp      <= 1'b0;
      col_kind <= '0;
      col_cnt  <= '0;
      pos      <= '0;
      bc       <= '0;
      acc      <= '0;
      bit_idx  <= '0;
    end else begin
      if (cmd.hdr_latch) begin
        nmp      <= (data_byte != 8'd0);
        col_kind <= value_kind;
        col_cnt  <= cnt_clamp;
      end
      if (cmd.clr_pos) begin
        pos <= '0;
      end else if (cmd.pos_inc) begin
        pos <= pos + CW'(1);
      end else if (cmd.pos_add8 || cmd.map_wr) begin
        pos <= pos_p8[CW-1:0];
      end
      if (cmd.clr_work) begin
        bc  <= '0;
        acc <= '0;
      end else if (cmd.acc_shift) begin
        bc  <= bc + 31'd1;
        acc <= acc_next;
      end else if (cmd.len_load) begin
        bc <= acc[30:0];
      end else if (cmd.bc_dec) begin
        bc <= bc - 31'd1;
      end
      if (cmd.bool_ld) begin
        bit_idx <= '0;
      end else if (cmd.bit_inc) begin
        bit_idx <= bit_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bool_ld) begin
      bbyte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      nmem[row_addr] <= data_byte;
    end
    row_q <= nmem[row_addr];
  end

  always_comb begin
    res_new.kind = cmd.emit_kind;
    res_new.vend = cmd.emit_end;
    res_new.hnm  = nmp;
    unique case (cmd.psel)
      PS_POS:  res_new.position = 10'(pos);
      PS_BIT:  res_new.position = 10'(pos_bit);
      default: res_new.position = '0;
    endcase
    unique case (cmd.vsel)
      VS_ACC:  res_new.value = acc;
      VS_BIT:  res_new.value = {63'd0, bbyte[~bit_idx]};
      VS_BYTE: res_new.value = {56'd0, data_byte};
      default: res_new.value = '0;
    endcase
  end

  assign push = pend_valid && (cmd.emit || cmd.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result_kind  <= pend.kind;
      position     <= pend.position;
      value        <= pend.value;
      value_end    <= pend.vend;
      had_null_map <= pend.hnm;
      last         <= cmd.flush;
    end
  end

  always_comb begin
    status.kind       = col_kind;
    status.cnt_zero   = (col_cnt == '0);
    status.nmp        = nmp;
    status.map_end    = (pos_p8 >= {1'b0, col_cnt});
    status.bc_full    = ((5'(bc[3:0]) + 5'd1) >= need);
    status.len_neg    = acc[31];
    status.len_zero   = (acc[31:0] == 32'd0);
    status.text_end   = (bc == 31'd1);
    status.pos_end    = (pos >= col_cnt);
    status.is_null    = row_q[~pos[2:0]];
    status.bit_ok     = (pos_bit < {1'b0, col_cnt}) && !(nmp && row_q[~bit_idx]);
    status.bit_last   = (bit_idx == 3'd7);
    status.pend_valid = pend_valid;
    status.slot_free  = !out_valid || out_ready;
    status.can_emit   = !pend_valid || !out_valid || out_ready;
  end

endmodule

/* src/ncsp_controller.sv */
// ----------------------------------------------------------------------------
// ncsp_controller
// Column phase and work state machine; drives datapath commands.
// ----------------------------------------------------------------------------
`include "nullable_column_stream_parser_unit_macros.svh"

module ncsp_controller import ncsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t st, st_next;
  phase_t ph, ph_next;
  logic   acc_in;
  phase_t found_ph;

  assign in_ready = (st == ST_WAIT);
  assign acc_in   = in_valid && in_ready;
  assign found_ph = (status.kind == KIND_TEXT) ? PH_TLEN : PH_FIXED;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_WAIT;
      ph <= PH_HDR;
    end else begin
      st <= st_next;
      ph <= ph_next;
    end
  end

  always_comb begin
    st_next = st;
    ph_next = ph;
    unique case (st)
      ST_WAIT: begin
        if (acc_in) begin
          unique case (ph)
            PH_HDR:    st_next = ST_HDRCHK;
            PH_NMAP:   st_next = status.map_end ? ST_BEGIN : ST_WAIT;
            PH_BMAP:   st_next = ST_BCHK;
            PH_FIXED:  st_next = status.bc_full ? ST_FEMIT : ST_WAIT;
            PH_TLEN:   st_next = status.bc_full ? ST_TCHK : ST_WAIT;
            PH_TBYTES: st_next = status.text_end ? ST_SKRD : ST_FLUSH;
            default:   st_next = ST_WAIT;
          endcase
        end
      end
      ST_HDRCHK: begin
        if (status.nmp && !status.cnt_zero) begin
          ph_next = PH_NMAP;
          st_next = ST_WAIT;
        end else begin
          st_next = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        if (status.kind == KIND_BOOL) begin
          ph_next = status.cnt_zero ? PH_HDR : PH_BMAP;
          st_next = ST_FLUSH;
        end else begin
          st_next = ST_SKRD;
        end
      end
      ST_BCHK: begin
        if ((!status.bit_ok || status.can_emit) && status.bit_last) begin
          st_next = ST_BEND;
        end
      end
      ST_BEND: begin
        if (!status.map_end) begin
          st_next = ST_FLUSH;
        end else if (status.can_emit) begin
          ph_next = PH_HDR;
          st_next = ST_FLUSH;
        end
      end
      ST_FEMIT: begin
        if (status.can_emit) begin
          st_next = ST_SKRD;
        end
      end
      ST_TCHK: begin
        if (status.len_neg) begin
          if (status.can_emit) begin
            ph_next = PH_HDR;
            st_next = ST_FLUSH;
          end
        end else if (status.len_zero) begin
          if (status.can_emit) begin
            st_next = ST_SKRD;
          end
        end else begin
          ph_next = PH_TBYTES;
          st_next = ST_FLUSH;
        end
      end
      ST_SKRD: begin
        if (status.pos_end) begin
          if (status.can_emit) begin
            ph_next = PH_HDR;
            st_next = ST_FLUSH;
          end
        end else if (!status.nmp) begin
          ph_next = found_ph;
          st_next = ST_FLUSH;
        end else begin
          st_next = ST_SKCHK;
        end
      end
      ST_SKCHK: begin
        if (status.is_null) begin
          st_next = ST_SKRD;
        end else begin
          ph_next = found_ph;
          st_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.slot_free) begin
          st_next = ST_WAIT;
        end
      end
      default: st_next = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.vsel = VS_ZERO;
    cmd.psel = PS_ZERO;
    unique case (st)
      ST_WAIT: begin
        if (acc_in) begin
          unique case (ph)
            PH_HDR:    cmd.hdr_latch = 1'b1;
            PH_NMAP:   cmd.map_wr = 1'b1;
            PH_BMAP:   cmd.bool_ld = 1'b1;
            PH_FIXED:  cmd.acc_shift = 1'b1;
            PH_TLEN:   cmd.acc_shift = 1'b1;
            PH_TBYTES: begin
              cmd.bc_dec    = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_kind = RK_TEXT;
              cmd.vsel      = VS_BYTE;
              cmd.psel      = PS_POS;
              cmd.emit_end  = status.text_end;
              cmd.pos_inc   = status.text_end;
            end
            default: cmd.emit = 1'b0;
          endcase
        end
      end
      ST_HDRCHK: begin
        cmd.clr_pos  = 1'b1;
        cmd.clr_work = 1'b1;
      end
      ST_BEGIN: begin
        cmd.clr_pos  = 1'b1;
        cmd.clr_work = 1'b1;
        if (status.kind == KIND_BOOL && status.cnt_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_DONE;
        end
      end
      ST_BCHK: begin
        if (!status.bit_ok || status.can_emit) begin
          cmd.emit      = status.bit_ok;
          cmd.emit_kind = RK_VALUE;
          cmd.vsel      = VS_BIT;
          cmd.psel      = PS_BIT;
          cmd.bit_inc   = !status.bit_last;
        end
      end
      ST_BEND: begin
        if (!status.map_end) begin
          cmd.pos_add8 = 1'b1;
        end else if (status.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_DONE;
        end
      end
      ST_FEMIT: begin
        if (status.can_emit) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = RK_VALUE;
          cmd.vsel      = VS_ACC;
          cmd.psel      = PS_POS;
          cmd.pos_inc   = 1'b1;
        end
      end
      ST_TCHK: begin
        if (status.len_neg) begin
          if (status.can_emit) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = RK_BADLEN;
            cmd.vsel      = VS_ACC;
            cmd.psel      = PS_POS;
          end
        end else if (status.len_zero) begin
          if (status.can_emit) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = RK_EMPTY;
            cmd.psel      = PS_POS;
            cmd.pos_inc   = 1'b1;
          end
        end else begin
          cmd.len_load = 1'b1;
        end
      end
      ST_SKRD: begin
        if (status.pos_end) begin
          if (status.can_emit) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = RK_DONE;
          end
        end else if (!status.nmp) begin
          cmd.clr_work = 1'b1;
        end
      end
      ST_SKCHK: begin
        if (status.is_null) begin
          cmd.pos_inc = 1'b1;
        end else begin
          cmd.clr_work = 1'b1;
        end
      end
      ST_FLUSH: begin
        cmd.flush = status.pend_valid && status.slot_free;
      end
      default: cmd.emit = 1'b0;
    endcase
  end

  // A new item is taken only once no result of the previous one waits in the pending register.
  `NCSP_ASSERT_SAME(a_ready_no_pend, clk, rst, in_ready, !status.pend_valid)
  // A result never overwrites a waiting one while the output is still full.
  `NCSP_ASSERT_SAME(a_emit_room, clk, rst, cmd.emit && status.pend_valid,
    status.slot_free)
  // The null search only runs when the column carried a bitmap.
  `NCSP_ASSERT_SAME(a_skchk_map, clk, rst, st == ST_SKCHK, status.nmp)
  // A finished step always returns to taking items.
  `NCSP_ASSERT_NEXT(a_flush_done, clk, rst,
    st == ST_FLUSH && (!status.pend_valid || status.slot_free), st == ST_WAIT)

endmodule

/* src/nullable_column_stream_parser_unit.sv */
// ----------------------------------------------------------------------------
// nullable_column_stream_parser_unit
// Parses a serialized nullable column one byte per item and returns value,
// text byte, empty text, done and bad length results.
//
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
// in        in         in_valid / in_ready     data_byte
// out       out        out_valid / out_ready   result_kind .. last
//
// A header byte is checked before the next byte is taken. A byte that completes
// a value, or the null bitmap of a non-boolean column, first skips the null
// positions after it. A boolean bitmap byte is worked one bit at a time.
// Reset is synchronous; the null bitmap memory is not cleared. A stalled
// output holds the state machine until the result register frees.
// ----------------------------------------------------------------------------
module nullable_column_stream_parser_unit import ncsp_pkg::*; #(
  parameter int MAX_POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [9:0]  position,
  output logic [63:0] value,
  output logic        value_end,
  output logic        had_null_map,
  output logic        last
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  ncsp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ncsp_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .result_kind  (result_kind),
    .position     (position),
    .value        (value),
    .value_end    (value_end),
    .had_null_map (had_null_map),
    .last         (last)
  );

endmodule
